### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Screen geometry, character codes, request codes and beat types.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned Cols  = 80;
  localparam int unsigned Rows  = 25;
  localparam int unsigned Cells = Cols * Rows;

  // column counter holds Cols itself (wrap pending)
  localparam int unsigned ColW  = $clog2(Cols + 1);
  localparam int unsigned RowW  = $clog2(Rows);
  localparam int unsigned AddrW = $clog2(Cells);

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChNull    = 8'h00;

  localparam logic [3:0] FgReset = 4'hF;
  localparam logic [3:0] BgReset = 4'h0;

  typedef enum logic [1:0] {
    ReqPut   = 2'd0,
    ReqClear = 2'd1,
    ReqRead  = 2'd2
  } req_e;

  typedef enum logic {
    CfgFg = 1'b0,
    CfgBg = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    StIdle,
    StRead
  } state_e;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } req_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
  } rsp_t;

  // logical screen row to physical store row, given the rotating top row
  function automatic logic [RowW-1:0] phys_row(input logic [RowW-1:0] lrow,
                                               input logic [RowW-1:0] top);
    logic [RowW:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (RowW+1)'(Rows)) begin
      sum = sum - (RowW+1)'(Rows);
    end
    return sum[RowW-1:0];
  endfunction

endpackage

### hw/rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit: text-mode console engine
// Put-character, clear and cell read over a store of 16-bit character cells.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid_i / in_stall_o | tcw_pkg::req_t  in_data_i
//  out     | output    | out_valid_o/out_stall_i | tcw_pkg::rsp_t  out_data_o
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Put, clear and unused requests load their result beat directly; a read
// waits in StRead for the registered read port of the cell memory.
// Scroll and clear need no pass over the memory: rows sit behind a rotating top-row
// pointer, and each row keeps a fill count and a blank colour, so cells past
// the fill count read as blanks without being written.
// Reset empties every row in flip-flops; no clearing pass over the memory.
// The input stalls while a read waits on memory or the output beat is held.
module text_console_writer_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tcw_pkg::req_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tcw_pkg::rsp_t  out_data_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [3:0]     cfg_data_i
);

  localparam int unsigned ColW  = tcw_pkg::ColW;
  localparam int unsigned RowW  = tcw_pkg::RowW;
  localparam int unsigned AddrW = tcw_pkg::AddrW;
  localparam int unsigned Rows  = tcw_pkg::Rows;
  localparam int unsigned Cols  = tcw_pkg::Cols;

  // cell memory, contents only meaningful below each row's fill count
  logic [15:0] cell_mem [tcw_pkg::Cells];
  logic [15:0] rd_data_q;

  tcw_pkg::state_e state_q, state_d;

  logic [3:0]      fg_q, bg_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d;
  logic [RowW-1:0] top_q, top_d;
  logic [ColW-1:0] fill_q  [Rows];
  logic [7:0]      blank_q [Rows];

  logic          out_valid_q;
  tcw_pkg::rsp_t out_q, out_d;

  logic rd_inrange_q, rd_hit_q;
  logic [7:0] rd_blank_q;

  logic accept, out_free, load_out;
  logic is_put, is_clear, is_read;
  logic put_go, is_nl, wrap, scroll, mem_we, mem_re;
  logic [ColW-1:0] col_n;
  logic [RowW-1:0] row_n, top_inc, wr_prow, rd_prow;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [7:0] colour;
  logic rd_inrange, rd_hit;

  assign out_free = !out_valid_q || !out_stall_i;
  assign accept   = in_valid_i && !in_stall_o;
  assign colour   = {bg_q, fg_q};

  // ---------------- state machine: next state ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcw_pkg::StIdle: begin
        if (accept && is_read) begin
          state_d = tcw_pkg::StRead;
        end
      end
      tcw_pkg::StRead: begin
        if (out_free) begin
          state_d = tcw_pkg::StIdle;
        end
      end
      default: state_d = tcw_pkg::StIdle;
    endcase
  end

  // ---------------- state machine: outputs ----------------
  always_comb begin
    in_stall_o = 1'b1;
    load_out   = 1'b0;
    unique case (state_q)
      tcw_pkg::StIdle: begin
        in_stall_o = !out_free;
        load_out   = accept && !is_read;
      end
      tcw_pkg::StRead: begin
        load_out = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
        load_out   = 1'b0;
      end
    endcase
  end

  // ---------------- request decode ----------------
  always_comb begin
    is_put   = 1'b0;
    is_clear = 1'b0;
    is_read  = 1'b0;
    unique case (in_data_i.req_type)
      tcw_pkg::ReqPut:   is_put   = 1'b1;
      tcw_pkg::ReqClear: is_clear = 1'b1;
      tcw_pkg::ReqRead:  is_read  = 1'b1;
      default: ;
    endcase
  end

  // ---------------- put datapath ----------------
  always_comb begin
    is_nl   = in_data_i.char_code == tcw_pkg::ChNewline;
    put_go  = accept && is_put && (in_data_i.char_code != tcw_pkg::ChNull);
    wrap    = (col_q >= ColW'(Cols)) || is_nl;
    scroll  = wrap && (row_q == RowW'(Rows - 1));
    top_inc = (top_q == RowW'(Rows - 1)) ? '0 : RowW'(top_q + 1'b1);

    col_n = wrap ? '0 : col_q;
    if (scroll) begin
      row_n = row_q;
    end else if (wrap) begin
      row_n = RowW'(row_q + 1'b1);
    end else begin
      row_n = row_q;
    end

    top_d = top_q;
    col_d = col_q;
    row_d = row_q;
    if (accept && is_clear) begin
      top_d = '0;
      col_d = '0;
      row_d = '0;
    end else if (put_go) begin
      top_d = scroll ? top_inc : top_q;
      row_d = row_n;
      col_d = is_nl ? col_n : ColW'(col_n + 1'b1);
    end

    wr_prow = tcw_pkg::phys_row(row_n, top_d);
    wr_addr = AddrW'(AddrW'(wr_prow) * AddrW'(Cols)) + AddrW'(col_n);
    mem_we  = put_go && !is_nl;
  end

  // ---------------- read datapath ----------------
  always_comb begin
    rd_inrange = (32'(in_data_i.read_row) < Rows) && (32'(in_data_i.read_col) < Cols);
    rd_prow    = tcw_pkg::phys_row(RowW'(in_data_i.read_row), top_q);
    rd_addr    = AddrW'(AddrW'(rd_prow) * AddrW'(Cols)) + AddrW'(in_data_i.read_col);
    rd_hit     = rd_inrange && (ColW'(in_data_i.read_col) < fill_q[rd_prow]);
    mem_re     = accept && is_read && rd_inrange;
  end

  // ---------------- result beat ----------------
  always_comb begin
    out_d            = out_q;
    out_d.cursor_col = 7'(col_d);
    out_d.cursor_row = 5'(row_d);
    out_d.cell_value = '0;
    if (state_q == tcw_pkg::StRead) begin
      out_d.cursor_col = 7'(col_q);
      out_d.cursor_row = 5'(row_q);
      if (rd_inrange_q) begin
        out_d.cell_value = rd_hit_q ? rd_data_q : {rd_blank_q, tcw_pkg::ChSpace};
      end
    end
  end

  // ---------------- cell memory ----------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      cell_mem[wr_addr] <= {colour, in_data_i.char_code};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= cell_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_read) begin
      rd_inrange_q <= rd_inrange;
      rd_hit_q     <= rd_hit;
      rd_blank_q   <= rd_inrange ? blank_q[rd_prow] : 8'h00;
    end
    if (load_out) begin
      out_q <= out_d;
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::StIdle;
      out_valid_q <= 1'b0;
      fg_q        <= tcw_pkg::FgReset;
      bg_q        <= tcw_pkg::BgReset;
      col_q       <= '0;
      row_q       <= '0;
      top_q       <= '0;
      for (int i = 0; i < Rows; i++) begin
        fill_q[i]  <= '0;
        blank_q[i] <= {tcw_pkg::BgReset, tcw_pkg::FgReset};
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcw_pkg::CfgFg: fg_q <= cfg_data_i;
          tcw_pkg::CfgBg: bg_q <= cfg_data_i;
          default: ;
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
      top_q <= top_d;
      if (accept && is_clear) begin
        for (int i = 0; i < Rows; i++) begin
          fill_q[i]  <= '0;
          blank_q[i] <= colour;
        end
      end else if (put_go) begin
        // old top row becomes the new bottom row, empty in current colours
        if (scroll) begin
          blank_q[top_q] <= colour;
        end
        // on a scroll the written cell lands in that same new bottom row
        if (!is_nl) begin
          fill_q[wr_prow] <= ColW'(col_n + 1'b1);
        end else if (scroll) begin
          fill_q[top_q] <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_accept_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (state_q == tcw_pkg::StIdle) && out_free)
    else $error("input taken while a result cannot be placed");

  a_nonread_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_read) |=> out_valid_q && (state_q == tcw_pkg::StIdle))
    else $error("non-read request did not produce its beat");

  a_read_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_read) |=> (state_q == tcw_pkg::StRead))
    else $error("read did not wait for memory data");

  a_cursor_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < RowW'(Rows)) && (col_q <= ColW'(Cols)) && (top_q < RowW'(Rows)))
    else $error("cursor or top row out of range");

  a_fill_tracks_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(mem_we) |-> fill_q[tcw_pkg::phys_row(row_q, top_q)] == col_q)
    else $error("row fill count disagrees with cursor after a write");
`endif

endmodule

### verif/text_console_writer_unit_chk.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit_chk: response checker for the text console writer
// Watches the request, response and register ports, keeps a shadow screen,
// cursor and colour set, and compares each response beat with the oldest
// predicted one. Mismatches are counted and handed to the testbench top.
// ----------------------------------------------------------------------------
module text_console_writer_unit_chk (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  tcw_pkg::req_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  tcw_pkg::rsp_t  out_data_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [3:0]     cfg_data_i,
  output int             pending_o,
  output int             errors_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [15:0] screen_cells [tcw_pkg::Cells];
  logic [6:0]  cur_col;
  logic [4:0]  cur_row;
  logic [3:0]  fg_nib;
  logic [3:0]  bg_nib;

  tcw_pkg::rsp_t rsp_q [$];
  int            mismatch_cnt = 0;

  assign errors_o = mismatch_cnt;

  function automatic logic [15:0] colored(input logic [7:0] ch);
    return {bg_nib, fg_nib, ch};
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < tcw_pkg::Cells; i++) begin
      screen_cells[i] = colored(tcw_pkg::ChSpace);
    end
  endfunction

  function automatic void scroll_up();
    for (int i = 0; i < (tcw_pkg::Rows - 1) * tcw_pkg::Cols; i++) begin
      screen_cells[i] = screen_cells[i + tcw_pkg::Cols];
    end
    for (int i = (tcw_pkg::Rows - 1) * tcw_pkg::Cols; i < tcw_pkg::Cells; i++) begin
      screen_cells[i] = colored(tcw_pkg::ChSpace);
    end
  endfunction

  function automatic void put_glyph(input logic [7:0] ch);
    if (ch == tcw_pkg::ChNull) return;
    if (cur_col >= tcw_pkg::Cols || ch == tcw_pkg::ChNewline) begin
      cur_col = '0;
      cur_row = cur_row + 5'd1;
    end
    if (cur_row >= tcw_pkg::Rows) begin
      scroll_up();
      cur_row = 5'(tcw_pkg::Rows - 1);
    end
    if (ch == tcw_pkg::ChNewline) return;
    screen_cells[int'(cur_row) * tcw_pkg::Cols + int'(cur_col)] = colored(ch);
    cur_col = cur_col + 7'd1;
  endfunction

  function automatic tcw_pkg::rsp_t console_step(input tcw_pkg::req_t rq);
    tcw_pkg::rsp_t r;
    r.cell_value = '0;
    case (rq.req_type)
      tcw_pkg::ReqPut: put_glyph(rq.char_code);
      tcw_pkg::ReqClear: begin
        blank_screen();
        cur_col = '0;
        cur_row = '0;
      end
      tcw_pkg::ReqRead: begin
        if (rq.read_row < tcw_pkg::Rows && rq.read_col < tcw_pkg::Cols) begin
          r.cell_value =
            screen_cells[int'(rq.read_row) * tcw_pkg::Cols + int'(rq.read_col)];
        end
      end
      default: ;
    endcase
    r.cursor_col = cur_col;
    r.cursor_row = cur_row;
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    if (mismatch_cnt < 100) begin
      $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    tcw_pkg::rsp_t want;
    if (!rst_ni) begin
      fg_nib  = tcw_pkg::FgReset;
      bg_nib  = tcw_pkg::BgReset;
      cur_col = '0;
      cur_row = '0;
      blank_screen();
      rsp_q.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        rsp_q.push_back(console_step(in_data_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (rsp_q.size() == 0) begin
          report("unexpected response beat", int'(out_data_i), 0);
        end else begin
          want = rsp_q.pop_front();
          if (out_data_i.cell_value != want.cell_value)
            report("cell_value", out_data_i.cell_value, want.cell_value);
          if (out_data_i.cursor_col != want.cursor_col)
            report("cursor_col", out_data_i.cursor_col, want.cursor_col);
          if (out_data_i.cursor_row != want.cursor_row)
            report("cursor_row", out_data_i.cursor_row, want.cursor_row);
        end
      end
      if (cfg_we_i) begin
        case (tcw_pkg::cfg_idx_e'(cfg_idx_i))
          tcw_pkg::CfgFg: fg_nib = cfg_data_i;
          tcw_pkg::CfgBg: bg_nib = cfg_data_i;
          default: ;
        endcase
      end
      pending_o <= rsp_q.size();
    end
  end

endmodule

### verif/text_console_writer_unit_tb.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb: testbench top for the text console writer
// Drives directed and random request beats with random gaps and output
// stalls, reprograms the colours between phases, and reports the verdict.
// ----------------------------------------------------------------------------
module text_console_writer_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseBeats  = 100;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  tcw_pkg::req_t in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  tcw_pkg::rsp_t out_data;
  logic          cfg_we = 1'b0;
  logic          cfg_idx = 1'b0;
  logic [3:0]    cfg_data = '0;

  int          pending;
  int          fail_count;
  int unsigned sent = 0;
  bit          quiet = 1'b0;

  text_console_writer_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  text_console_writer_unit_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (fail_count)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAIL text_console_writer_unit");
    $finish;
  end

  // mostly short idles, a few long ones; none in quiet phases
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  initial begin : rsp_stall
    int unsigned run;
    forever begin
      run = $urandom_range(1, 6);
      repeat (run) begin
        @(posedge clk_i);
        out_stall <= 1'b0;
      end
      run = pick_gap();
      repeat (run) begin
        @(posedge clk_i);
        out_stall <= 1'b1;
      end
    end
  end

  task automatic send_beat(input tcw_pkg::req_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (in_stall);
    sent++;
  endtask

  task automatic send_req(input logic [1:0] kind, input logic [7:0] ch,
                          input logic [4:0] row, input logic [6:0] col);
    tcw_pkg::req_t b;
    b.req_type  = kind;
    b.char_code = ch;
    b.read_row  = row;
    b.read_col  = col;
    send_beat(b);
  endtask

  // unused fields carry random bits
  task automatic send_put(input logic [7:0] ch);
    send_req(tcw_pkg::ReqPut, ch, 5'($urandom), 7'($urandom));
  endtask

  task automatic send_read(input logic [4:0] row, input logic [6:0] col);
    send_req(tcw_pkg::ReqRead, 8'($urandom), row, col);
  endtask

  task automatic send_random_read();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60)
      send_read(5'($urandom_range(0, tcw_pkg::Rows - 1)),
                7'($urandom_range(0, tcw_pkg::Cols - 1)));
    else if (r < 80)
      send_read(($urandom_range(0, 1) != 0) ? 5'(tcw_pkg::Rows - 1) : 5'd0,
                7'($urandom_range(0, tcw_pkg::Cols - 1)));
    else
      send_read(5'($urandom), 7'($urandom));
  endtask

  // wait out all responses plus the read latency before touching registers
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input tcw_pkg::cfg_idx_e idx, input logic [3:0] val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_line();
    int unsigned r;
    int unsigned len;
    r = $urandom_range(0, 99);
    if (r < 70)      len = $urandom_range(0, 12);
    else if (r < 90) len = $urandom_range(13, 60);
    else             len = $urandom_range(tcw_pkg::Cols - 4, tcw_pkg::Cols + 4);
    repeat (len) begin
      if ($urandom_range(0, 9) == 0) send_put(8'($urandom));
      else                           send_put(8'($urandom_range(8'h21, 8'hFF)));
    end
    if ($urandom_range(0, 3) != 0) send_put(tcw_pkg::ChNewline);
  endtask

  initial begin : stimulus
    int unsigned r;
    int unsigned goal;
    logic [3:0] fg;
    logic [3:0] bg;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset contents, character extremes, null, newline,
    // out-of-range reads, the unused request code and clear
    send_read(5'd0, 7'd0);
    send_read(5'(tcw_pkg::Rows - 1), 7'(tcw_pkg::Cols - 1));
    send_put(8'h41);
    send_put(tcw_pkg::ChNull);
    send_put(8'hFF);
    send_put(8'h01);
    send_put(tcw_pkg::ChNewline);
    send_put(8'h80);
    send_read(5'd0, 7'd0);
    send_read(5'd0, 7'd1);
    send_read(5'd0, 7'd2);
    send_read(5'd0, 7'd3);
    send_read(5'd1, 7'd0);
    send_read(5'(tcw_pkg::Rows), 7'd0);
    send_read(5'd0, 7'(tcw_pkg::Cols));
    send_read(5'h1F, 7'h7F);
    send_req(ReqUnused, 8'hFF, 5'h1F, 7'h7F);
    send_req(ReqUnused, 8'h00, 5'h00, 7'h00);
    send_req(tcw_pkg::ReqClear, 8'hFF, 5'h1F, 7'h7F);
    send_read(5'd0, 7'd0);
    send_read(5'd1, 7'd0);
    send_put(8'h7E);
    send_read(5'd0, 7'd0);

    for (int phase = 0; phase < NumPhases; phase++) begin
      drain();
      case (phase)
        0:       begin fg = 4'h0; bg = 4'h0; end
        1:       begin fg = 4'hF; bg = 4'hF; end
        2:       begin fg = tcw_pkg::FgReset; bg = tcw_pkg::BgReset; end
        3:       begin fg = 4'h0; bg = 4'hF; end
        default: begin fg = 4'($urandom); bg = 4'($urandom); end
      endcase
      write_reg(tcw_pkg::CfgFg, fg);
      write_reg(tcw_pkg::CfgBg, bg);
      quiet = (phase % 3 == 2);
      goal = sent + PhaseBeats;
      while (sent < goal) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          send_line();
        end else if (r < 90) begin
          send_random_read();
        end else if (r < 96) begin
          // burst of newlines moves the cursor down and scrolls once it reaches the bottom
          repeat ($urandom_range(1, tcw_pkg::Rows)) send_put(tcw_pkg::ChNewline);
        end else if (r < 98) begin
          send_req(ReqUnused, 8'($urandom), 5'($urandom), 7'($urandom));
        end else begin
          send_req(tcw_pkg::ReqClear, 8'($urandom), 5'($urandom), 7'($urandom));
        end
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS text_console_writer_unit");
    end else begin
      $display("FAIL text_console_writer_unit");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/tcw_pkg.sv
hw/rtl/text_console_writer_unit.sv
verif/text_console_writer_unit_chk.sv
verif/text_console_writer_unit_tb.sv
